// ===== rtl/tfn_pkg.sv =====
// types and constants shared by the triangle face normal unit
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int unsigned SqrtSteps = 51;
  localparam int unsigned DivSteps  = 15;
  localparam int unsigned FrontSteps = 5;
  localparam logic [14:0] QMax = 15'd16384;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by_coord;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_t;

  // square root chain payload
  typedef struct packed {
    logic [2:0][33:0] m;
    logic [2:0]       neg;
    logic [67:0]      s;
    logic [53:0]      rem;
    logic [50:0]      root;
  } sq_t;

  // division chain payload
  typedef struct packed {
    logic [2:0][65:0] r;
    logic [2:0][14:0] q;
    logic [2:0]       neg;
    logic [50:0]      len;
  } dv_t;

endpackage

// ===== rtl/tfn_if.sv =====
// request channels of the triangle face normal unit
`timescale 1ns / 1ps
interface tfn_in_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfn_out_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tfn_front.sv =====
// edge vectors, cross product, magnitudes and squared length
`timescale 1ns / 1ps
module tfn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          en_i,
  input  logic                valid_i,
  input  tfn_pkg::in_t        data_i,
  output logic [4:0]          valid_o,
  output tfn_pkg::sq_t        data_o
);
  import tfn_pkg::*;

  logic [4:0] valid_q;
  logic signed [16:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [33:0] p_q [6];
  logic [2:0][33:0] m_q;
  logic [2:0]       neg_q, neg2_q;
  logic [2:0][67:0] sqr_q;
  logic [2:0][33:0] m2_q;
  logic signed [34:0] n_d [3];
  sq_t out_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < 5; k++) begin
        if (en_i[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // edges
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ux_q <= 17'(data_i.bx) - 17'(data_i.ax);
      uy_q <= 17'(data_i.by_coord) - 17'(data_i.ay);
      uz_q <= 17'(data_i.bz) - 17'(data_i.az);
      vx_q <= 17'(data_i.cx) - 17'(data_i.ax);
      vy_q <= 17'(data_i.cy) - 17'(data_i.ay);
      vz_q <= 17'(data_i.cz) - 17'(data_i.az);
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q[0] <= uy_q * vz_q;
      p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q;
      p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q;
      p_q[5] <= uy_q * vx_q;
    end
  end

  // cross components and their magnitudes
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_d[c] = 35'(p_q[2*c]) - 35'(p_q[2*c+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= n_d[c][34];
        m_q[c]   <= n_d[c][34] ? 34'(-n_d[c]) : 34'(n_d[c]);
      end
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int c = 0; c < 3; c++) begin
        sqr_q[c] <= 68'(m_q[c]) * 68'(m_q[c]);
      end
      m2_q   <= m_q;
      neg2_q <= neg_q;
    end
  end

  // squared length
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      out_q.s    <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      out_q.m    <= m2_q;
      out_q.neg  <= neg2_q;
      out_q.rem  <= '0;
      out_q.root <= '0;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;
endmodule

// ===== rtl/tfn_sqrt_cell.sv =====
// one root bit of the length square root
`timescale 1ns / 1ps
module tfn_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  tfn_pkg::sq_t data_i,
  output logic         valid_o,
  output tfn_pkg::sq_t data_o
);
  import tfn_pkg::*;

  localparam int unsigned Hi = 101 - 2 * Step;

  logic         valid_q;
  sq_t          data_q, data_d;
  logic [101:0] rad;
  logic [55:0]  cur, trial;

  // restoring step on the next radicand pair
  always_comb begin
    rad    = {2'b00, data_i.s, 32'd0};
    cur    = {data_i.rem, rad[Hi -: 2]};
    trial  = {3'b000, data_i.root, 2'b01};
    data_d = data_i;
    if (cur >= trial) begin
      data_d.rem  = 54'(cur - trial);
      data_d.root = {data_i.root[49:0], 1'b1};
    end else begin
      data_d.rem  = 54'(cur);
      data_d.root = {data_i.root[49:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== rtl/tfn_div_cell.sv =====
// one quotient bit of the three normalizing divisions
`timescale 1ns / 1ps
module tfn_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  tfn_pkg::dv_t data_i,
  output logic         valid_o,
  output tfn_pkg::dv_t data_o
);
  import tfn_pkg::*;

  logic        valid_q;
  dv_t         data_q, data_d;
  logic [65:0] dvs;

  // compare and subtract per component
  always_comb begin
    dvs    = 66'(data_i.len) << Bit;
    data_d = data_i;
    for (int c = 0; c < 3; c++) begin
      if (data_i.r[c] >= dvs) begin
        data_d.r[c] = data_i.r[c] - dvs;
        data_d.q[c] = {data_i.q[c][13:0], 1'b1};
      end else begin
        data_d.q[c] = {data_i.q[c][13:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== rtl/triangle_face_normal_unit.sv =====
// Triangle face normal: cross product, square root chain, division chain.
// Each request passes through the front end, the square root cells, the division cells and the output register.
// Throughput: one request per cycle; a full stage holds while its successor cannot move.
// The square root takes 51 cells and the division 15, one bit per cell.
// Reset clears all stage valids and sets length threshold to 0.
`timescale 1ns / 1ps
module triangle_face_normal_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  tfn_in_if.sink        in_i,
  tfn_out_if.source     out_o
);
  import tfn_pkg::*;

  localparam int unsigned NStg = FrontSteps + SqrtSteps + DivSteps + 1;

  logic [15:0]     thr_q;
  logic [NStg-1:0] vld;
  logic [NStg-1:0] en;
  sq_t             sq [SqrtSteps+1];
  dv_t             dv [DivSteps+1];
  logic            out_valid_q;
  out_t            out_q, out_d;
  logic [14:0]     qc;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  assign en[NStg-1] = !out_valid_q || out_o.ready;
  assign vld[NStg-1] = out_valid_q;
  for (genvar k = 0; k < NStg - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_i.ready = en[0];

  // front end
  tfn_front u_front (
    .clk_i,
    .rst_ni,
    .en_i    (en[4:0]),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (vld[4:0]),
    .data_o  (sq[0])
  );

  // square root cells
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    tfn_sqrt_cell #(.Step(j)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en[FrontSteps+j]),
      .valid_i (vld[FrontSteps+j-1]),
      .data_i  (sq[j]),
      .valid_o (vld[FrontSteps+j]),
      .data_o  (sq[j+1])
    );
  end

  // dividend with half the divisor added for rounding
  always_comb begin
    dv[0].len = sq[SqrtSteps].root;
    dv[0].neg = sq[SqrtSteps].neg;
    dv[0].q   = '0;
    for (int c = 0; c < 3; c++) begin
      dv[0].r[c] = {sq[SqrtSteps].m[c], 30'd0} + 66'(sq[SqrtSteps].root[50:1]);
    end
  end

  // division cells
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    tfn_div_cell #(.Bit(DivSteps - 1 - k)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en[FrontSteps+SqrtSteps+k]),
      .valid_i (vld[FrontSteps+SqrtSteps+k-1]),
      .data_i  (dv[k]),
      .valid_o (vld[FrontSteps+SqrtSteps+k]),
      .data_o  (dv[k+1])
    );
  end

  // clamp, sign and threshold test
  always_comb begin
    logic [15:0] nv [3];
    for (int c = 0; c < 3; c++) begin
      qc    = (dv[DivSteps].q[c] > QMax) ? QMax : dv[DivSteps].q[c];
      nv[c] = dv[DivSteps].neg[c] ? 16'(-{1'b0, qc}) : {1'b0, qc};
    end
    out_d.degenerate = (dv[DivSteps].len[50:16] <= 35'(thr_q));
    out_d.normal_x   = out_d.degenerate ? '0 : nv[0];
    out_d.normal_y   = out_d.degenerate ? '0 : nv[1];
    out_d.normal_z   = out_d.degenerate ? '0 : nv[2];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NStg-1]) begin
      out_valid_q <= vld[NStg-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NStg-1]) out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.degenerate |->
      out_q.normal_x == 0 && out_q.normal_y == 0 && out_q.normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // an empty output stage lets the whole chain move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output stage");

  // components stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      out_q.normal_x >= -16384 && out_q.normal_x <= 16384 &&
      out_q.normal_y >= -16384 && out_q.normal_y <= 16384 &&
      out_q.normal_z >= -16384 && out_q.normal_z <= 16384)
    else $error("normal component out of range");
endmodule

// ===== test/triangle_face_normal_unit_tb.sv =====
// self-checking testbench for the triangle face normal unit
`timescale 1ns / 1ps
module triangle_face_normal_unit_tb;
  import tfn_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 100;

  typedef struct {
    in_t tri_data;
    bit  hold_off;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  tfn_in_if in_ch();
  tfn_out_if out_ch();

  triangle_face_normal_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  pending_t triangles_q[$];
  out_t normals_q[$];
  logic [15:0] threshold = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit in_fired = 1'b0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // expected normal of one triangle
  function automatic out_t face_normal(input in_t t, input logic [15:0] thr);
    longint ux, uy, uz, vx, vy, vz;
    longint n[3];
    logic [127:0] m[3];
    logic [127:0] sq, c, r, q;
    out_t o;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by_coord) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    n[0] = uy * vz - uz * vy;
    n[1] = uz * vx - ux * vz;
    n[2] = ux * vy - uy * vx;
    for (int i = 0; i < 3; i++) m[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
    sq = (m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) << 32;
    r = '0;
    for (int b = 51; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sq) r = c;
    end
    o = '0;
    if ((r >> 16) <= 128'(thr) || r == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      if (q > 128'd16384) q = 128'd16384;
      if (n[i] < 0) q = -q;
      case (i)
        0: o.normal_x = q[15:0];
        1: o.normal_y = q[15:0];
        default: o.normal_z = q[15:0];
      endcase
    end
    return o;
  endfunction

  // request driver, changes at the falling edge
  always @(negedge clk_i) begin
    logic nv;
    in_t nd;
    nv = in_ch.valid;
    nd = in_ch.data;
    if (!in_ch.valid || in_fired) begin
      nv = 1'b0;
      if (triangles_q.size() > 0 && rst_ni &&
          !(triangles_q[0].hold_off && normals_q.size() > 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        nv = 1'b1;
        nd = triangles_q.pop_front().tri_data;
      end
    end
    in_ch.valid <= nv;
    in_ch.data <= nd;
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and checker at the rising edge
  always @(posedge clk_i) begin
    out_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("[triangle_face_normal_unit] ERROR");
      $finish;
    end
    in_fired = in_ch.valid && in_ch.ready;
    if (in_fired) normals_q.insert(normals_q.size(), face_normal(in_ch.data, threshold));
    if (out_ch.valid && out_ch.ready) begin
      if (normals_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_ch.data);
      end else begin
        want = normals_q.pop_front();
        if (out_ch.data.normal_x !== want.normal_x) begin
          errors++;
          $display("%0t normal_x exp %0d got %0d", $time, want.normal_x,
                   out_ch.data.normal_x);
        end
        if (out_ch.data.normal_y !== want.normal_y) begin
          errors++;
          $display("%0t normal_y exp %0d got %0d", $time, want.normal_y,
                   out_ch.data.normal_y);
        end
        if (out_ch.data.normal_z !== want.normal_z) begin
          errors++;
          $display("%0t normal_z exp %0d got %0d", $time, want.normal_z,
                   out_ch.data.normal_z);
        end
        if (out_ch.data.degenerate !== want.degenerate) begin
          errors++;
          $display("%0t degenerate exp %0b got %0b", $time, want.degenerate,
                   out_ch.data.degenerate);
        end
      end
    end
  end

  function automatic in_t make_tri(input int a[9]);
    in_t t;
    t.ax = 16'(a[0]); t.ay = 16'(a[1]); t.az = 16'(a[2]);
    t.bx = 16'(a[3]); t.by_coord = 16'(a[4]); t.bz = 16'(a[5]);
    t.cx = 16'(a[6]); t.cy = 16'(a[7]); t.cz = 16'(a[8]);
    return t;
  endfunction

  task automatic push_tri(input in_t t, input bit hold);
    pending_t p;
    p.tri_data = t;
    p.hold_off = hold;
    triangles_q.insert(triangles_q.size(), p);
  endtask

  // random triangle: full range, small range, collinear or tiny
  function automatic in_t rand_tri();
    int a[9];
    int kind, span, k;
    kind = $urandom_range(9);
    span = (kind < 4) ? 65536 : (kind < 7) ? (1 << $urandom_range(12, 2)) : 64;
    for (int i = 0; i < 9; i++)
      a[i] = (span == 65536) ? int'($signed(16'($urandom())))
                             : int'($urandom_range(span - 1)) - span / 2;
    if (kind == 9) begin
      k = $urandom_range(3);
      for (int i = 0; i < 3; i++) a[6 + i] = a[i] + k * (a[3 + i] - a[i]);
    end
    return make_tri(a);
  endfunction

  task automatic write_threshold(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  task automatic drain();
    while (triangles_q.size() > 0 || normals_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int d[9];
    logic [15:0] thr_list[5];
    thr_list = '{16'd0, 16'd65535, 16'd1, 16'd200, 16'd0};
    thr_list[3] = 16'($urandom_range(65535));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 54; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 10; recv_stall_pct = 40; end
      endcase
      if (ph > 0) write_threshold(thr_list[ph]);
      if (ph == 0) begin
        // zero triangle, extremes, axis-aligned units, collinear points
        d = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; push_tri(make_tri(d), 0);
        d = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        push_tri(make_tri(d), 0);
        d = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        push_tri(make_tri(d), 0);
        d = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
        push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 256, 0, 0, 0, 256, 0}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 0, 256, 0, 0, 0, 256}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 0, 0, 256, 256, 0, 0}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 0, 256, 0, 256, 0, 0}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; push_tri(make_tri(d), 0);
        d = '{5, 5, 5, 6, 7, 8, 7, 9, 11}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 3, 1, 0, 1, 3, 0}; push_tri(make_tri(d), 0);
        d = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 32767, 1, 0, 1, 32767, 0}; push_tri(make_tri(d), 0);
        d = '{0, 0, 0, 1000, 3, 7, -5, 1000, 2}; push_tri(make_tri(d), 0);
        d = '{100, -200, 300, -400, 500, -600, 700, -800, 900}; push_tri(make_tri(d), 0);
      end
      for (int i = 0; i < 185; i++) push_tri(rand_tri(), (ph == 2 && i == 90));
      drain();
    end
    write_threshold(16'd0);
    if (errors == 0 && normals_q.size() == 0) begin
      $display("[triangle_face_normal_unit] OK");
    end else begin
      $display("[triangle_face_normal_unit] ERROR");
    end
    $finish;
  end

endmodule
